// ===== src/phic_pkg.sv =====
// shared types and constants for the pseudo-header internet checksum block
`timescale 1ns / 1ps
`default_nettype none

package phic_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W = 8;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_USE_PSEUDO_HEADER = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_COMPLEMENT_RESULT = cfg_idx_t'(1);

  // byte count codes of a data word
  localparam logic [1:0] BYTES_NONE = 2'd0;
  localparam logic [1:0] BYTES_ONE  = 2'd1;

  // sum width and the mask that keeps the upper byte of an odd final word
  localparam int unsigned SUM_W      = 16;
  localparam logic [15:0] SUM_MASK   = 16'hffff;
  localparam logic [15:0] UPPER_BYTE = 16'hff00;

  typedef logic [SUM_W-1:0] sum_t;

  // one input transaction as held in the input register
  typedef struct packed {
    logic        start_packet;
    logic [15:0] initial_sum;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] seg_length;
    logic [15:0] data_word;
    logic [1:0]  byte_count;
    logic        last;
  } item_t;

endpackage

`default_nettype wire

// ===== src/phic_sum.sv =====
// ones' complement adder: pseudo-header, running sum and data word in one pass
`timescale 1ns / 1ps
`default_nettype none

module phic_sum import phic_pkg::*; (
  input  item_t item_i,
  input  logic  use_pseudo_header_i,
  input  sum_t  running_sum_i,
  output sum_t  next_sum_o
);

  // up to eight 16-bit terms, so three carry bits above the sum
  localparam int unsigned TOTAL_W = SUM_W + 3;

  logic [TOTAL_W-1:0] base;
  logic [TOTAL_W-1:0] header;
  logic [TOTAL_W-1:0] word_term;
  logic [TOTAL_W-1:0] total;
  logic [SUM_W:0]     fold1;
  sum_t               fold2;

  // pseudo-header words: address halves, zero byte with protocol, length; zero when the pseudo-header is off
  always_comb begin
    header = TOTAL_W'(item_i.src_addr[31:16]) + TOTAL_W'(item_i.src_addr[15:0])
           + TOTAL_W'(item_i.dst_addr[31:16]) + TOTAL_W'(item_i.dst_addr[15:0])
           + TOTAL_W'(item_i.protocol)        + TOTAL_W'(item_i.seg_length);
    if (!use_pseudo_header_i) begin
      header = '0;
    end
  end

  // packet start restarts from the initial sum
  always_comb begin
    if (item_i.start_packet) begin
      base = TOTAL_W'(item_i.initial_sum) + header;
    end else begin
      base = TOTAL_W'(running_sum_i);
    end
  end

  // data word, odd final byte padded with a zero low byte
  always_comb begin
    case (item_i.byte_count)
      BYTES_NONE: word_term = '0;
      BYTES_ONE:  word_term = TOTAL_W'(item_i.data_word & UPPER_BYTE);
      default:    word_term = TOTAL_W'(item_i.data_word);
    endcase
  end

  // end-around carry folded twice; zero stays zero only when every term is zero
  assign total      = base + word_term;
  assign fold1      = (SUM_W+1)'(total[SUM_W-1:0]) + (SUM_W+1)'(total[TOTAL_W-1:SUM_W]);
  assign fold2      = fold1[SUM_W-1:0] + sum_t'(fold1[SUM_W]);
  assign next_sum_o = fold2;

endmodule

`default_nettype wire

// ===== src/pseudo_header_internet_checksum.sv =====
// top level of the streaming internet checksum with optional pseudo-header
`timescale 1ns / 1ps
`default_nettype none

// Takes one 16-bit network-order word per cycle and keeps a ones' complement
// running sum. A word with start_packet set restarts from initial_sum and, when
// register 0 is set, adds the pseudo-header (source and destination address
// halves, zero byte with protocol, segment length). A word with last set
// yields one checksum, inverted when register 1 is set, and clears the sum.
// An accepted word sits in the input register while the adder folds it into the
// sum; a checksum is registered in the result register once its last word
// leaves the input register. Sustained rate is one word per cycle while the
// input does not stall, set by the feedback of the running sum through the adder.
// The input stalls only when a finished checksum is still waiting and another
// last word is ready to leave the input register. Configuration writes are always
// taken and must be made while no word is in flight.
module pseudo_header_internet_checksum import phic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  cfg_idx_t    cfg_index_i,
  input  logic        cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_packet_i,
  input  logic [15:0] initial_sum_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] seg_length_i,
  input  logic [15:0] data_word_i,
  input  logic [1:0]  byte_count_i,
  input  logic        last_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] checksum_o
);

  logic  use_ph_q;
  logic  comp_q;
  logic  in_vld_q;
  item_t in_q;
  sum_t  run_sum_q;
  logic  out_vld_q;
  sum_t  out_sum_q;

  logic  in_accept;
  logic  out_free;
  logic  advance;
  sum_t  next_sum;
  item_t in_item;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_ph_q <= 1'b1;
      comp_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_USE_PSEUDO_HEADER) begin
        use_ph_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_COMPLEMENT_RESULT) begin
        comp_q <= cfg_data_i;
      end
    end
  end

  // handshake: the input register empties unless its last word meets a full, stalled output
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!in_q.last || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_item.start_packet = start_packet_i;
    in_item.initial_sum  = initial_sum_i;
    in_item.src_addr     = src_addr_i;
    in_item.dst_addr     = dst_addr_i;
    in_item.protocol     = protocol_i;
    in_item.seg_length   = seg_length_i;
    in_item.data_word    = data_word_i;
    in_item.byte_count   = byte_count_i;
    in_item.last         = last_i;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept || advance) begin
      in_vld_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item;
    end
  end

  // ones' complement accumulation
  phic_sum u_sum (
    .item_i              (in_q),
    .use_pseudo_header_i (use_ph_q),
    .running_sum_i       (run_sum_q),
    .next_sum_o          (next_sum)
  );

  // running sum, cleared once a packet's checksum is produced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sum_q <= '0;
    end else if (advance) begin
      run_sum_q <= in_q.last ? sum_t'(0) : next_sum;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance && in_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last) begin
      out_sum_q <= comp_q ? (next_sum ^ SUM_MASK) : next_sum;
    end
  end

  assign out_valid_o = out_vld_q;
  assign checksum_o  = out_sum_q;

endmodule

`default_nettype wire

// ===== src/phic_checker.sv =====
// port-level checks for the pseudo-header internet checksum block
`timescale 1ns / 1ps
`default_nettype none

module phic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] checksum_o
);

  // a waiting checksum stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a waiting checksum keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(checksum_o))
    else $error("result changed while stalled");

  // the input only stalls behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled with a free output");

  // a fresh stall always holds the transaction taken on the previous edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stalled with no transaction held");

endmodule

bind pseudo_header_internet_checksum phic_checker u_phic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .checksum_o  (checksum_o)
);

`default_nettype wire
